@@ design/pidas_pkg.sv @@
// Shared types and constants for the angle servo with clamp and trip.
// Used by the shared multiply-shift unit and by the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package pidas_pkg;

  typedef enum logic [2:0] {
    OP_INTEG = 3'd0,
    OP_DIFF  = 3'd1,
    OP_POLE  = 3'd2,
    OP_PROP  = 3'd3,
    OP_IGAIN = 3'd4,
    OP_DGAIN = 3'd5,
    OP_ANGLE = 3'd6
  } op_t;

  typedef struct packed {
    logic        go;
    logic        neg;
    op_t         tag;
    logic [48:0] amag;
    logic [31:0] bmag;
  } mul_req_t;

  typedef struct packed {
    logic        rdy;
    logic        vld;
    op_t         tag;
    logic [61:0] val;
  } mul_rsp_t;

  localparam logic [2:0] CFG_ENC_ZERO = 3'd0;
  localparam logic [2:0] CFG_KP       = 3'd1;
  localparam logic [2:0] CFG_KI       = 3'd2;
  localparam logic [2:0] CFG_KD       = 3'd3;
  localparam logic [2:0] CFG_PERIOD   = 3'd4;
  localparam logic [2:0] CFG_DSCALE   = 3'd5;
  localparam logic [2:0] CFG_POLE     = 3'd6;
  localparam logic [2:0] CFG_LIMIT    = 3'd7;

  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_HI   = 2'd1;
  localparam logic [1:0] CLAMP_LO   = 2'd2;

  localparam logic [63:0] PROD_CAP = 64'h1000_0000_0000_0000;
  localparam logic [31:0] PI_Q28   = 32'd843314857;

endpackage

@@ design/pid_angle_servo_with_clamp_and_trip.sv @@
// Angle servo top level: PID with filtered derivative, drive clamp and overcurrent trip.
// Sequences seven products through the shared unit pidas_mulsh.
// Depends on pidas_pkg and pidas_mulsh.
//
//   Port group  Dir   Beat contents
//   in_*        in    setpoint, encoder count, motor and brake current, brake request
//   out_*       out   motor and brake drive with clamp codes, angle, overcurrent
//   cfg_*       in    one register write per cycle with cfg_we high
//
// Each input beat is finished before the next is accepted; once the fault has
// tripped only the angle product is issued. The seven products share one multiplier.
// Reset clears the controller state, the fault and the registers (limit to 5 V).
// A stalled output holds the finished beat; the next input waits until it is loaded.
`timescale 1ns / 1ps

module pid_angle_servo_with_clamp_and_trip #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int DRIVE_FRAC_BITS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // angle_target[31:0], encoder_count[63:32], motor_current[79:64],
  // brake_current[95:80], brake_request[111:96]
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // motor_drive[15:0], motor_clamp[17:16], brake_drive[33:18], brake_clamp[35:34],
  // measured_angle[67:36], overcurrent[68], zero[71:69]
  output logic [71:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);
  import pidas_pkg::*;

  localparam int GAIN_SHIFT  = 16 + ANGLE_FRAC_BITS - DRIVE_FRAC_BITS;
  localparam int ANGLE_SHIFT = 40 - ANGLE_FRAC_BITS;
  localparam int LIMIT_RAW   = 5 << DRIVE_FRAC_BITS;
  localparam int LIMIT_INIT  = (LIMIT_RAW > 32767) ? 32767 : LIMIT_RAW;
  localparam logic [14:0] LIMIT_RST = 15'(LIMIT_INIT);
  localparam logic signed [17:0] ILIM_M = 18'((24 << DRIVE_FRAC_BITS) / 10);
  localparam logic signed [17:0] ILIM_B = 18'((19 << DRIVE_FRAC_BITS) / 100);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } st_t;

  st_t                st_r;
  op_t                iss_r;
  logic               iss_done_r;
  logic               fault_r;
  logic               trip_r;
  logic signed [31:0] last_angle_r;
  logic signed [47:0] integ_acc_r;
  logic signed [31:0] prev_error_r;
  logic signed [31:0] deriv_acc_r;
  logic signed [63:0] acc_r;
  logic signed [31:0] e_r;
  logic signed [32:0] adiff_r;
  logic signed [15:0] br_r;
  logic               out_tvalid_r;
  logic [71:0]        out_tdata_r;

  logic signed [31:0] zero_r;
  logic signed [31:0] kp_r;
  logic signed [31:0] ki_r;
  logic signed [31:0] kd_r;
  logic [23:0]        period_r;
  logic [30:0]        dscale_r;
  logic [23:0]        pole_r;
  logic [14:0]        limit_r;

  mul_req_t           req;
  mul_rsp_t           rsp;
  logic signed [48:0] a_val;
  logic signed [32:0] b_val;
  logic signed [48:0] a_abs;
  logic signed [32:0] b_abs;
  logic signed [63:0] term;
  logic               in_fire;
  logic               out_load;
  logic signed [17:0] im_x;
  logic signed [17:0] ib_x;
  logic signed [63:0] lim64;
  logic signed [15:0] lim16;
  logic [15:0]        m_drv;
  logic [1:0]         m_code;
  logic [15:0]        b_drv;
  logic [1:0]         b_code;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sd140737488355327) begin
      return 48'sh7fff_ffff_ffff;
    end else if (v < -64'sd140737488355328) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r   <= '0;
      kp_r     <= '0;
      ki_r     <= '0;
      kd_r     <= '0;
      period_r <= '0;
      dscale_r <= '0;
      pole_r   <= '0;
      limit_r  <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ENC_ZERO: zero_r   <= cfg_wdata;
        CFG_KP:       kp_r     <= cfg_wdata;
        CFG_KI:       ki_r     <= cfg_wdata;
        CFG_KD:       kd_r     <= cfg_wdata;
        CFG_PERIOD:   period_r <= cfg_wdata[23:0];
        CFG_DSCALE:   dscale_r <= cfg_wdata[30:0];
        CFG_POLE:     pole_r   <= cfg_wdata[23:0];
        CFG_LIMIT:    limit_r  <= cfg_wdata[14:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (iss_r)
      OP_INTEG: begin
        a_val = 49'(e_r);
        b_val = {9'd0, period_r};
      end
      OP_DIFF: begin
        a_val = 49'(33'(e_r) - 33'(prev_error_r));
        b_val = {2'd0, dscale_r};
      end
      OP_POLE: begin
        a_val = 49'(deriv_acc_r);
        b_val = {9'd0, pole_r};
      end
      OP_PROP: begin
        a_val = 49'(e_r);
        b_val = 33'(kp_r);
      end
      OP_IGAIN: begin
        a_val = 49'(integ_acc_r);
        b_val = 33'(ki_r);
      end
      OP_DGAIN: begin
        a_val = 49'(deriv_acc_r);
        b_val = 33'(kd_r);
      end
      OP_ANGLE: begin
        a_val = 49'(adiff_r);
        b_val = {1'b0, PI_Q28};
      end
      default: begin
        a_val = '0;
        b_val = '0;
      end
    endcase
  end

  assign a_abs    = a_val[48] ? -a_val : a_val;
  assign b_abs    = b_val[32] ? -b_val : b_val;
  assign req.go   = (st_r == ST_RUN) && !iss_done_r && rsp.rdy;
  assign req.neg  = a_val[48] ^ b_val[32];
  assign req.tag  = iss_r;
  assign req.amag = a_abs;
  assign req.bmag = b_abs[31:0];

  pidas_mulsh #(
    .GAIN_SHIFT  (GAIN_SHIFT),
    .ANGLE_SHIFT (ANGLE_SHIFT)
  ) u_mulsh (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign term      = 64'(signed'(rsp.val));
  assign in_tready = (st_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (st_r == ST_FINISH) && (!out_tvalid_r || out_tready);
  assign im_x      = 18'(signed'(in_tdata[79:64]));
  assign ib_x      = 18'(signed'(in_tdata[95:80]));
  assign lim64     = signed'({49'd0, limit_r});
  assign lim16     = signed'({1'b0, limit_r});

  always_comb begin
    if (acc_r > lim64) begin
      m_drv  = lim16;
      m_code = CLAMP_HI;
    end else if (acc_r < -lim64) begin
      m_drv  = -lim16;
      m_code = CLAMP_LO;
    end else begin
      m_drv  = acc_r[15:0];
      m_code = CLAMP_NONE;
    end
    if (br_r > lim16) begin
      b_drv  = lim16;
      b_code = CLAMP_HI;
    end else if (br_r < -lim16) begin
      b_drv  = -lim16;
      b_code = CLAMP_LO;
    end else begin
      b_drv  = br_r;
      b_code = CLAMP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      iss_r        <= OP_INTEG;
      iss_done_r   <= 1'b0;
      fault_r      <= 1'b0;
      last_angle_r <= '0;
      integ_acc_r  <= '0;
      prev_error_r <= '0;
      deriv_acc_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      case (st_r)
        ST_IDLE: begin
          if (in_fire) begin
            iss_r      <= fault_r ? OP_ANGLE : OP_INTEG;
            iss_done_r <= 1'b0;
            st_r       <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (req.go) begin
            if (iss_r == OP_ANGLE) begin
              iss_done_r <= 1'b1;
            end else begin
              iss_r <= op_t'(iss_r + 3'd1);
            end
          end
          if (rsp.vld) begin
            case (rsp.tag)
              OP_INTEG: integ_acc_r <= sat48(64'(integ_acc_r) + term);
              OP_POLE: begin
                deriv_acc_r  <= sat32(acc_r + term);
                prev_error_r <= e_r;
              end
              OP_ANGLE: begin
                last_angle_r <= sat32(-term);
                st_r         <= ST_FINISH;
              end
              default: ;
            endcase
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            fault_r <= fault_r | trip_r;
            st_r    <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
    if (in_fire) begin
      e_r     <= sat32(64'(signed'(in_tdata[31:0])) - 64'(last_angle_r));
      adiff_r <= 33'(signed'(in_tdata[63:32])) - 33'(zero_r);
      br_r    <= in_tdata[111:96];
      trip_r  <= (im_x > ILIM_M) || (im_x < -ILIM_M) || (ib_x > ILIM_B) || (ib_x < -ILIM_B);
    end
    if (rsp.vld) begin
      case (rsp.tag)
        OP_DIFF, OP_PROP:  acc_r <= term;
        OP_IGAIN, OP_DGAIN: acc_r <= acc_r + term;
        default: ;
      endcase
    end
    if (out_load) begin
      out_tdata_r <= {3'd0, fault_r | trip_r, last_angle_r,
                      fault_r ? 36'd0 : {b_code, b_drv, m_code, m_drv}};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef NO_ASSERTIONS
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fault_r |=> fault_r)
    else $error("overcurrent fault cleared without reset");

  a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.vld |-> st_r == ST_RUN)
    else $error("product returned outside of a sample");

  a_fault_skips_pid: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && fault_r |=> iss_r == OP_ANGLE)
    else $error("tripped sample did not go straight to the angle product");
`endif

endmodule

@@ design/pidas_mulsh.sv @@
// Shared multiply-shift unit: one 25x32 multiplier used twice per product,
// then a truncating shift with a magnitude cap and the sign applied.
// Depends on pidas_pkg.
`timescale 1ns / 1ps

module pidas_mulsh #(
  parameter int GAIN_SHIFT  = 28,
  parameter int ANGLE_SHIFT = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pidas_pkg::mul_req_t req,
  output pidas_pkg::mul_rsp_t rsp
);
  import pidas_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HI,
    PH_LO
  } ph_t;

  ph_t         ph_r, ph_nxt;
  logic [48:0] amag_r;
  logic [31:0] bmag_r;
  logic        neg_r;
  op_t         tag_r;
  logic [56:0] hi_r;
  logic [55:0] lo_r;
  logic        shp_go_r;
  logic        shp_neg_r;
  op_t         shp_tag_r;
  logic        res_vld_r;
  op_t         res_tag_r;
  logic [61:0] res_val_r;

  logic [24:0] mul_a;
  logic [56:0] prod;
  logic [60:0] mag;
  logic [61:0] mag62;

  // The product hi * 2^24 + lo, shifted right by s, truncated and capped at 2^60.
  function automatic logic [60:0] shape(input logic [56:0] hi, input logic [55:0] lo,
                                        input int unsigned s);
    int unsigned up;
    int unsigned dn;
    logic [63:0] m;
    up = (s < 24) ? 24 - s : 0;
    dn = (s >= 24) ? s - 24 : 0;
    if (s >= 24) begin
      m = ({7'd0, hi} + {32'd0, lo[55:24]}) >> dn;
    end else if ({7'd0, hi} > (PROD_CAP >> up)) begin
      m = PROD_CAP;
    end else begin
      m = ({7'd0, hi} << up) + ({8'd0, lo} >> s);
    end
    if (m > PROD_CAP) begin
      m = PROD_CAP;
    end
    return m[60:0];
  endfunction

  assign mul_a = (ph_r == PH_HI) ? amag_r[48:24] : {1'b0, amag_r[23:0]};
  assign prod  = 57'(mul_a * bmag_r);

  always_comb begin
    case (shp_tag_r)
      OP_INTEG, OP_POLE: mag = shape(hi_r, lo_r, 24);
      OP_DIFF:           mag = shape(hi_r, lo_r, 16);
      OP_ANGLE:          mag = shape(hi_r, lo_r, ANGLE_SHIFT);
      default:           mag = shape(hi_r, lo_r, GAIN_SHIFT);
    endcase
  end

  assign mag62 = {1'b0, mag};

  always_comb begin
    case (ph_r)
      PH_IDLE: ph_nxt = req.go ? PH_HI : PH_IDLE;
      PH_HI:   ph_nxt = PH_LO;
      PH_LO:   ph_nxt = req.go ? PH_HI : PH_IDLE;
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= PH_IDLE;
      shp_go_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      ph_r      <= ph_nxt;
      shp_go_r  <= (ph_r == PH_LO);
      res_vld_r <= shp_go_r;
    end
    if (req.go) begin
      amag_r <= req.amag;
      bmag_r <= req.bmag;
      neg_r  <= req.neg;
      tag_r  <= req.tag;
    end
    if (ph_r == PH_HI) begin
      hi_r <= prod;
    end
    if (ph_r == PH_LO) begin
      lo_r      <= prod[55:0];
      shp_neg_r <= neg_r;
      shp_tag_r <= tag_r;
    end
    if (shp_go_r) begin
      res_val_r <= shp_neg_r ? (~mag62 + 62'd1) : mag62;
      res_tag_r <= shp_tag_r;
    end
  end

  assign rsp.rdy = (ph_r == PH_IDLE) || (ph_r == PH_LO);
  assign rsp.vld = res_vld_r;
  assign rsp.tag = res_tag_r;
  assign rsp.val = res_val_r;

endmodule
